// File: sv/interval_clock_calibrator_unit_macros.svh
// Assertion macros shared by the calibrator RTL.
// Used by the files that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef INTERVAL_CLOCK_CALIBRATOR_UNIT_MACROS_SVH
`define INTERVAL_CLOCK_CALIBRATOR_UNIT_MACROS_SVH

// Check that is switched off while reset is held.
`define ICC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that also runs across reset.
`define ICC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: sv/icc_pkg.sv
// Package for the interval clock calibrator: widths, constants, register codes.
// Shared request/response types of the serial divider. No dependencies.
`timescale 1ns / 1ps

package icc_pkg;

    localparam int NUM_TIMERS = 9;
    localparam int TIMER_W    = $clog2(NUM_TIMERS);
    localparam int TIMER_IN_W = 4;
    localparam int TIME_W     = 48;
    localparam int RATE_W     = 31;
    localparam int WIN_W      = 24;
    localparam int TPS_W      = 32;
    localparam int TICK_W     = 30;
    localparam int USEC_W     = 20;
    localparam int PROD_W     = TIME_W + USEC_W;
    localparam int QUOT_W     = RATE_W + 1;
    localparam int LEN_W      = $clog2(PROD_W + 1);
    localparam int SMALL_PAD  = PROD_W - RATE_W;
    localparam int MUL_CNT_W  = $clog2(USEC_W + 1);

    localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);
    localparam logic [QUOT_W-1:0] MAX_TICK     = QUOT_W'(32'h3FFF_FFFF);
    localparam logic [RATE_W-1:0] MAX_RATE     = {RATE_W{1'b1}};
    localparam logic [RATE_W-1:0] RATE_RESET   = RATE_W'(500000);
    localparam logic [WIN_W-1:0]  WIN_RESET    = WIN_W'(200000);
    localparam logic [TIME_W-1:0] QRY_DIVISOR  = TIME_W'(100);
    localparam logic [LEN_W-1:0]  LEN_WIDE     = LEN_W'(PROD_W);
    localparam logic [LEN_W-1:0]  LEN_SMALL    = LEN_W'(RATE_W);

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = RATE_W;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_USEC  = 1'b1;

    localparam logic KIND_CAL   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [TIME_W-1:0] divisor;
        logic [LEN_W-1:0]  len;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

// File: sv/icc_mul.sv
// Bit-serial multiplier of a 48-bit count delta by one million.
// One multiplier bit per cycle, MSB first. Depends on icc_pkg.
`timescale 1ns / 1ps

module icc_mul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [icc_pkg::TIME_W-1:0] i_a,
    output logic                      o_done,
    output logic [icc_pkg::PROD_W-1:0] o_prod
);
    import icc_pkg::*;

    logic [PROD_W-1:0]    r_acc;
    logic [TIME_W-1:0]    r_a;
    logic [USEC_W-1:0]    r_k;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [PROD_W-1:0]    n_acc;

    assign n_acc = {r_acc[PROD_W-2:0], 1'b0} + (r_k[USEC_W-1] ? PROD_W'(r_a) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CNT_W'(USEC_W);
                r_acc  <= '0;
                r_a    <= i_a;
                r_k    <= USEC_PER_SEC;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_k   <= {r_k[USEC_W-2:0], 1'b0};
                r_cnt <= r_cnt - MUL_CNT_W'(1);
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: sv/icc_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, quotient frozen once its top bit, 2^31, is set.
// Shared by the rate measurement, the per-tick division and the query division. Depends on icc_pkg.
`timescale 1ns / 1ps
`include "interval_clock_calibrator_unit_macros.svh"

module icc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  icc_pkg::t_div_req i_req,
    output icc_pkg::t_div_rsp o_rsp
);
    import icc_pkg::*;

    logic [PROD_W-1:0] r_dvd;
    logic [TIME_W-1:0] r_div;
    logic [TIME_W-1:0] r_rem;
    logic [QUOT_W-1:0] r_q;
    logic [LEN_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [TIME_W:0]   rem_sh;
    logic [TIME_W:0]   rem_sub;
    logic              ge;

    assign rem_sh  = {r_rem, r_dvd[PROD_W-1]};
    assign ge      = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.len;
                r_dvd  <= i_req.dividend;
                r_div  <= i_req.divisor;
                r_rem  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[PROD_W-2:0], 1'b0};
                r_rem <= ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
                // top bit is sticky: once set the quotient is out of 31-bit range
                r_q   <= r_q[QUOT_W-1] ? r_q : {r_q[QUOT_W-2:0], ge};
                r_cnt <= r_cnt - LEN_W'(1);
                if (r_cnt == LEN_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

    `ICC_ASSERT(a_div_no_restart, i_req.start |-> !r_busy, "divider restarted while busy")
    `ICC_ASSERT(a_div_cnt_live, r_busy |-> (r_cnt != '0), "divider busy with no steps left")
    `ICC_ASSERT(a_div_rem_bound, r_busy |-> (r_rem < r_div), "remainder not below divisor")

endmodule

// File: sv/interval_clock_calibrator_unit.sv
// Top level of the interval clock calibrator: control sequencer, per-timer base and
// per-tick stores, configuration registers. Uses icc_pkg, icc_mul and icc_div.
//
//  channel  direction  handshake                 payload
//  in       sink       i_in_valid / o_in_ready   i_kind i_timer i_now_usec
//                                                i_executed_count i_ticks_per_second
//  out      source     o_out_valid / i_out_ready o_tick_value
//  cfg      sink       i_cfg_we (no wait)        i_cfg_index i_cfg_data
//
// One item at a time. A query with a stored per-tick value is answered from the store; a
// query without one divides the rate by 100 in the shared bit-serial divider. A calibrate
// item divides the rate by ticks per second unless that is zero; one that re-measures
// first runs the serial multiplier and a divider pass that yields the new rate.
// Reset is synchronous and clears all base and per-tick valid bits and the rate.
// A finished item waits in the output register; the next item is taken meanwhile, and
// holds in its last cycle while that register is still full.
`timescale 1ns / 1ps
`include "interval_clock_calibrator_unit_macros.svh"

module interval_clock_calibrator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [icc_pkg::TIMER_IN_W-1:0] i_timer,
    input  logic [icc_pkg::TIME_W-1:0]    i_now_usec,
    input  logic [icc_pkg::TIME_W-1:0]    i_executed_count,
    input  logic [icc_pkg::TPS_W-1:0]     i_ticks_per_second,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [icc_pkg::RATE_W-1:0]    o_tick_value,
    input  logic                          i_cfg_we,
    input  logic [icc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [icc_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import icc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EVAL = 7'b0000010,
        S_RATE = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_MEAS = 7'b0010000,
        S_TICK = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state             r_state;
    logic               r_kind;
    logic [TIMER_W-1:0] r_t;
    logic [TIME_W-1:0]  r_now;
    logic [TIME_W-1:0]  r_cnt;
    logic [TPS_W-1:0]   r_tps;
    logic [TIME_W-1:0]  r_span;
    logic [RATE_W-1:0]  r_init;
    logic [WIN_W-1:0]   r_win;
    logic [RATE_W-1:0]  r_meas;
    logic [RATE_W-1:0]  r_res;
    logic               r_clamp;
    logic               r_out_valid;
    logic [RATE_W-1:0]  r_out_val;

    logic [TIME_W-1:0]  r_bt  [NUM_TIMERS];
    logic [TIME_W-1:0]  r_bc  [NUM_TIMERS];
    logic [TICK_W-1:0]  r_pt  [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_bv;
    logic [NUM_TIMERS-1:0] r_ptv;

    logic [TIME_W-1:0]  bt;
    logic [TIME_W-1:0]  bc;
    logic [TIME_W-1:0]  span;
    logic [WIN_W-1:0]   win_eff;
    logic [RATE_W-1:0]  rate_cur;
    logic               meas_ok;
    logic [TIMER_W-1:0] t_in;
    logic [QUOT_W-1:0]  q;
    logic [TICK_W-1:0]  pt_new;

    logic               mul_start;
    logic               mul_done;
    logic [PROD_W-1:0]  mul_prod;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    assign t_in     = (i_timer >= TIMER_IN_W'(NUM_TIMERS - 1)) ? TIMER_W'(NUM_TIMERS - 1)
                                                                : TIMER_W'(i_timer);
    assign bt       = r_bt[r_t];
    assign bc       = r_bc[r_t];
    assign span     = r_now - bt;
    assign win_eff  = (r_win == '0) ? WIN_W'(1) : r_win;
    assign meas_ok  = r_bv[r_t] && (r_now >= bt) && (span >= TIME_W'(win_eff))
                      && (r_cnt > bc);
    assign rate_cur = (r_meas != '0) ? r_meas : r_init;
    assign q        = div_rsp.quot;
    assign pt_new   = (q == '0) ? TICK_W'(1) : (q > MAX_TICK) ? MAX_TICK[TICK_W-1:0]
                                                             : q[TICK_W-1:0];
    assign mul_start = (r_state == S_EVAL) && (r_kind == KIND_CAL) && meas_ok;

    always_comb begin
        div_req = '0;
        unique case (r_state)
            S_EVAL: begin
                if (r_kind == KIND_QUERY && !r_ptv[r_t]) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {rate_cur, {SMALL_PAD{1'b0}}};
                    div_req.divisor  = QRY_DIVISOR;
                    div_req.len      = LEN_SMALL;
                end
            end
            S_RATE: begin
                if (r_tps != '0) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {rate_cur, {SMALL_PAD{1'b0}}};
                    div_req.divisor  = TIME_W'(r_tps);
                    div_req.len      = LEN_SMALL;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = mul_prod;
                    div_req.divisor  = r_span;
                    div_req.len      = LEN_WIDE;
                end
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    icc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_cnt - bc),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    icc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_meas      <= '0;
            r_init      <= RATE_RESET;
            r_win       <= WIN_RESET;
            r_bv        <= '0;
            r_ptv       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_INITIAL_RATE: r_init <= i_cfg_data;
                    REG_WINDOW_USEC:  r_win  <= i_cfg_data[WIN_W-1:0];
                    default:          r_init <= r_init;
                endcase
            end
            if (r_out_valid && i_out_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_kind  <= i_kind;
                        r_t     <= t_in;
                        r_now   <= i_now_usec;
                        r_cnt   <= i_executed_count;
                        r_tps   <= i_ticks_per_second;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_kind == KIND_QUERY) begin
                        r_clamp <= 1'b0;
                        if (r_ptv[r_t]) begin
                            r_res   <= RATE_W'(r_pt[r_t]);
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_TICK;
                        end
                    end else begin
                        r_span <= span;
                        if (!r_bv[r_t] || meas_ok) begin
                            r_bt[r_t] <= r_now;
                            r_bc[r_t] <= r_cnt;
                            r_bv[r_t] <= 1'b1;
                        end
                        r_state <= meas_ok ? S_MUL : S_RATE;
                    end
                end
                S_RATE: begin
                    if (r_tps == '0) begin
                        r_res   <= rate_cur;
                        r_state <= S_FIN;
                    end else begin
                        r_clamp <= 1'b1;
                        r_state <= S_TICK;
                    end
                end
                S_MUL: begin
                    if (mul_done) begin
                        r_state <= S_MEAS;
                    end
                end
                S_MEAS: begin
                    if (div_rsp.done) begin
                        // zero would read as "not measured", so it is stored as one
                        r_meas  <= q[QUOT_W-1] ? MAX_RATE :
                                   (q == '0) ? RATE_W'(1) : q[RATE_W-1:0];
                        r_state <= S_RATE;
                    end
                end
                S_TICK: begin
                    if (div_rsp.done) begin
                        if (r_clamp) begin
                            r_pt[r_t]  <= pt_new;
                            r_ptv[r_t] <= 1'b1;
                            r_res      <= RATE_W'(pt_new);
                        end else begin
                            r_res <= q[RATE_W-1:0];
                        end
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_val   <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_tick_value = r_out_val;

    `ICC_ASSERT(a_one_item_at_a_time, (i_in_valid && o_in_ready) |=> !o_in_ready, "ready held after accept")
    `ICC_ASSERT(a_meas_nonzero, (r_state == S_RATE && $past(r_state == S_MEAS)) |-> (r_meas != '0), "measured rate left zero")
    `ICC_ASSERT(a_tick_nonzero, (r_state == S_FIN && $past(r_state == S_TICK) && r_clamp) |-> (r_res != '0), "per-tick value zero")
    `ICC_ASSERT_RST(a_reset_idle, !i_rst_n |=> (!o_out_valid && r_state == S_IDLE), "not idle after reset")

endmodule

// File: sim/tb.sv
// Testbench for interval_clock_calibrator_unit: directed and random calibrate and query items,
// random stalls on both channels, every tick value checked against an in-bench predictor.
// Depends on icc_pkg and the calibrator RTL only.
`timescale 1ns / 1ps

module tb;
    import icc_pkg::*;

    localparam int     HALF_PERIOD_NS   = 6;
    localparam int     RESET_CYCLES     = 9;
    localparam int     DRAIN_CYCLES     = 150;
    localparam int     RANDOM_PHASES    = 6;
    localparam int     HALF_PHASE_ITEMS = 95;
    localparam int     MAX_PRINTED      = 100;
    localparam longint WATCHDOG_NS      = 64'd12_000_000;

    localparam logic [RATE_W-1:0] RATE_CEIL      = 31'h7FFF_FFFF;
    localparam logic [TPS_W-1:0]  TICK_CEIL      = 32'h3FFF_FFFF;
    localparam logic [PROD_W-1:0] MICROS_PER_SEC = 68'd1_000_000;
    localparam logic [RATE_W-1:0] QUERY_DIVISOR  = 31'd100;
    localparam logic [RATE_W-1:0] INIT_RATE_RST  = 31'd500_000;
    localparam logic [WIN_W-1:0]  WINDOW_RST     = 24'd200_000;
    localparam logic [TIME_W-1:0] TIME_TOP       = '1;
    localparam logic [TIME_W-1:0] TIME_HALF      = 48'h8000_0000_0000;
    localparam logic [TPS_W-1:0]  TPS_TOP        = '1;

    typedef struct packed {
        logic                  kind;
        logic [TIMER_IN_W-1:0] timer;
        logic [TIME_W-1:0]     now_usec;
        logic [TIME_W-1:0]     executed_count;
        logic [TPS_W-1:0]      ticks_per_second;
    } calib_item_t;

    typedef struct {
        logic [TIME_W-1:0] base_time  [NUM_TIMERS];
        logic [TIME_W-1:0] base_count [NUM_TIMERS];
        logic              base_valid [NUM_TIMERS];
        logic [RATE_W-1:0] rate_meas;
        logic [TICK_W-1:0] tick_store [NUM_TIMERS];
    } calib_state_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    calib_item_t          in_item   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [RATE_W-1:0]    tick_value;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;
    logic                 in_taken  = 1'b0;

    calib_item_t       pending_items_q[$];
    logic [RATE_W-1:0] tick_expect_q[$];
    calib_state_t      model_state;
    calib_state_t      plan_state;
    logic [RATE_W-1:0] cfg_initial_rate = INIT_RATE_RST;
    logic [WIN_W-1:0]  cfg_window       = WINDOW_RST;
    int unsigned       send_idle_pct    = 0;
    int unsigned       recv_idle_pct    = 0;
    int                n_pushed         = 0;
    int                n_accepted       = 0;
    int                n_mismatches     = 0;

    interval_clock_calibrator_unit i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_kind             (in_item.kind),
        .i_timer            (in_item.timer),
        .i_now_usec         (in_item.now_usec),
        .i_executed_count   (in_item.executed_count),
        .i_ticks_per_second (in_item.ticks_per_second),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_tick_value       (tick_value),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    always #(HALF_PERIOD_NS) clk = ~clk;

    // Advances the calibrator state by one item and returns its tick value.
    function automatic logic [RATE_W-1:0] calibrate_step(inout calib_state_t st,
                                                         input calib_item_t it);
        int unsigned       slot;
        logic [RATE_W-1:0] rate;
        logic [WIN_W-1:0]  win;
        logic [TIME_W-1:0] span;
        logic [PROD_W-1:0] quot;
        logic [TPS_W-1:0]  tick_val;
        slot = (it.timer >= NUM_TIMERS) ? NUM_TIMERS - 1 : it.timer;
        if (it.kind == KIND_CAL) begin
            if (!st.base_valid[slot]) begin
                st.base_time[slot]  = it.now_usec;
                st.base_count[slot] = it.executed_count;
                st.base_valid[slot] = 1'b1;
            end else begin
                win  = (cfg_window == '0) ? WIN_W'(1) : cfg_window;
                span = it.now_usec - st.base_time[slot];
                if (it.now_usec >= st.base_time[slot] && span >= TIME_W'(win)
                        && it.executed_count > st.base_count[slot]) begin
                    quot = PROD_W'(it.executed_count - st.base_count[slot]) * MICROS_PER_SEC
                           / PROD_W'(span);
                    if (quot > PROD_W'(RATE_CEIL)) begin
                        st.rate_meas = RATE_CEIL;
                    end else if (quot == '0) begin
                        st.rate_meas = RATE_W'(1);
                    end else begin
                        st.rate_meas = quot[RATE_W-1:0];
                    end
                    st.base_time[slot]  = it.now_usec;
                    st.base_count[slot] = it.executed_count;
                end
            end
        end
        rate = (st.rate_meas != '0) ? st.rate_meas : cfg_initial_rate;
        if (it.kind == KIND_QUERY) begin
            if (st.tick_store[slot] != '0) return RATE_W'(st.tick_store[slot]);
            return rate / QUERY_DIVISOR;
        end
        if (it.ticks_per_second == '0) return rate;
        tick_val = TPS_W'(rate) / it.ticks_per_second;
        if (tick_val == '0) begin
            tick_val = TPS_W'(1);
        end else if (tick_val > TICK_CEIL) begin
            tick_val = TICK_CEIL;
        end
        st.tick_store[slot] = TICK_W'(tick_val);
        return RATE_W'(tick_val);
    endfunction

    task automatic report_mismatch(input string what);
        if (n_mismatches < MAX_PRINTED) $display("%0t ns: %s", $time, what);
        n_mismatches++;
    endtask

    task automatic queue_item(input calib_item_t it);
        pending_items_q.push_back(it);
        n_pushed++;
    endtask

    // Block is idle only once every item is in and every tick value is back.
    task automatic settle();
        do @(negedge clk); while (n_accepted != n_pushed || tick_expect_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_INITIAL_RATE) begin
            cfg_initial_rate = data[RATE_W-1:0];
        end else begin
            cfg_window = data[WIN_W-1:0];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Driver: new item or bubble at the falling edge; receiver stalls alongside.
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && (!in_valid || in_taken)) begin
            if (pending_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_item  <= pending_items_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin : monitor
        logic [RATE_W-1:0] want;
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready) begin
            tick_expect_q.push_back(calibrate_step(model_state, in_item));
            n_accepted++;
        end
        if (rst_n && out_valid && out_ready) begin
            if (tick_expect_q.size() == 0) begin
                report_mismatch($sformatf("tick value 0x%08h with none expected", tick_value));
            end else begin
                want = tick_expect_q.pop_front();
                if (tick_value !== want) begin
                    report_mismatch($sformatf("tick value 0x%08h, expected 0x%08h",
                                              tick_value, want));
                end
            end
        end
    end

    initial begin : stimulus
        int                phase;
        calib_item_t       it;
        int unsigned       slot;
        int unsigned       pick;
        logic [TIME_W-1:0] win;
        logic [TIME_W-1:0] base_t;
        logic [TIME_W-1:0] base_c;
        logic [TIME_W-1:0] step;
        for (int s = 0; s < NUM_TIMERS; s++) begin
            model_state.base_time[s]  = '0;
            model_state.base_count[s] = '0;
            model_state.base_valid[s] = 1'b0;
            model_state.tick_store[s] = '0;
        end
        model_state.rate_meas = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 33;
        recv_idle_pct = 67;

        // reset register values, first request, inside the window
        queue_item('{KIND_QUERY, 4'd0, TIME_TOP, TIME_TOP, TPS_TOP});
        queue_item('{KIND_CAL, 4'd0, 48'd1000, 48'd0, 32'd0});
        queue_item('{KIND_CAL, 4'd0, 48'd200_999, 48'd5000, 32'd100});
        queue_item('{KIND_QUERY, 4'd0, 48'd0, 48'd0, 32'd0});
        settle();
        // zero initial rate
        write_reg(REG_INITIAL_RATE, '0);
        queue_item('{KIND_QUERY, 4'd1, 48'd0, 48'd0, 32'd0});
        queue_item('{KIND_CAL, 4'd1, 48'd0, 48'd0, 32'd0});
        queue_item('{KIND_CAL, 4'd1, 48'd5, 48'd5, 32'd5});
        settle();
        // top initial rate, zero window, saturated measurement
        write_reg(REG_INITIAL_RATE, CFG_DAT_W'(RATE_CEIL));
        write_reg(REG_WINDOW_USEC, '0);
        queue_item('{KIND_QUERY, 4'd2, 48'd0, 48'd0, 32'd0});
        queue_item('{KIND_CAL, 4'd2, 48'd0, 48'd0, 32'd1});
        queue_item('{KIND_CAL, 4'd0, 48'd1001, 48'd5, 32'd0});
        queue_item('{KIND_CAL, 4'd2, 48'd1, 48'd3000, 32'd1});
        settle();
        // top window, time backwards, count stuck, slot folding, tiny rate
        write_reg(REG_WINDOW_USEC, CFG_DAT_W'(24'hFF_FFFF));
        queue_item('{KIND_QUERY, 4'd9, 48'd0, 48'd0, 32'd0});
        queue_item('{KIND_CAL, 4'd0, 48'd500, 48'd100, 32'd3});
        queue_item('{KIND_CAL, 4'd0, TIME_TOP, 48'd0, TPS_TOP});
        queue_item('{KIND_CAL, 4'd15, 48'd0, 48'd0, 32'd7});
        queue_item('{KIND_QUERY, 4'd15, 48'd0, 48'd0, 32'd0});
        queue_item('{KIND_CAL, 4'd3, 48'd0, 48'd0, 32'd0});
        queue_item('{KIND_CAL, 4'd3, TIME_HALF, 48'd1, 32'd2});
        queue_item('{KIND_CAL, 4'd3, TIME_HALF, 48'd2, 32'd0});
        queue_item('{KIND_QUERY, 4'd4, 48'd0, 48'd0, 32'd0});
        queue_item('{KIND_CAL, 4'd4, 48'd0, 48'd0, 32'd1000});
        queue_item('{KIND_CAL, 4'd4, 48'h100_0000, 48'h100_0000, 32'd1000});
        settle();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_INITIAL_RATE, CFG_DAT_W'(1));
                    write_reg(REG_WINDOW_USEC, CFG_DAT_W'(1));
                end
                1: begin
                    write_reg(REG_INITIAL_RATE, CFG_DAT_W'($urandom_range(32'h7FFF_FFFF, 1)));
                    write_reg(REG_WINDOW_USEC, CFG_DAT_W'(WINDOW_RST));
                end
                2: begin
                    write_reg(REG_INITIAL_RATE, CFG_DAT_W'(RATE_CEIL));
                    write_reg(REG_WINDOW_USEC, CFG_DAT_W'(24'hFF_FFFF));
                end
                3: begin
                    write_reg(REG_INITIAL_RATE, CFG_DAT_W'($urandom_range(32'h7FFF_FFFF, 1)));
                    write_reg(REG_WINDOW_USEC, CFG_DAT_W'($urandom_range(1_000_000, 1)));
                end
                4: begin
                    write_reg(REG_INITIAL_RATE, CFG_DAT_W'(INIT_RATE_RST));
                    write_reg(REG_WINDOW_USEC, CFG_DAT_W'(1000));
                end
                default: begin
                    write_reg(REG_INITIAL_RATE, CFG_DAT_W'($urandom_range(32'h7FFF_FFFF, 1)));
                    write_reg(REG_WINDOW_USEC, CFG_DAT_W'($urandom_range(24'hFF_FFFF, 1)));
                end
            endcase
            send_idle_pct = (phase < 2) ? 33 : (phase < 4) ? 67 : 0;
            recv_idle_pct = (phase < 2) ? 67 : (phase < 4) ? 33 : 0;
            repeat (2) begin
                // plan against a shadow so that most requests land past the window
                plan_state = model_state;
                win = (cfg_window == '0) ? TIME_W'(1) : TIME_W'(cfg_window);
                repeat (HALF_PHASE_ITEMS) begin
                    it.kind           = KIND_CAL;
                    it.timer          = TIMER_IN_W'($urandom_range(15));
                    it.now_usec       = TIME_W'({$urandom, $urandom});
                    it.executed_count = TIME_W'({$urandom, $urandom});
                    slot   = (it.timer >= NUM_TIMERS) ? NUM_TIMERS - 1 : it.timer;
                    base_t = plan_state.base_time[slot];
                    base_c = plan_state.base_count[slot];
                    step   = (TIME_W'({$urandom, $urandom}) >> $urandom_range(47, 8)) + 1'b1;
                    pick   = $urandom_range(99);
                    if (pick < 20) begin
                        it.kind = KIND_QUERY;
                    end else if (pick < 68) begin
                        it.now_usec       = base_t + win + $urandom_range(win[31:0]);
                        it.executed_count = base_c + step;
                    end else if (pick < 78) begin
                        it.now_usec       = base_t + $urandom_range(win[31:0] - 1);
                        it.executed_count = base_c + step;
                    end else if (pick < 85) begin
                        it.now_usec = (base_t > 48'd5000) ?
                                      base_t - 1 - $urandom_range(4999) : base_t >> 1;
                        it.executed_count = base_c + step;
                    end else if (pick < 92) begin
                        it.now_usec       = base_t + win + $urandom_range(win[31:0]);
                        it.executed_count = base_c >> $urandom_range(1);
                    end
                    case ($urandom_range(4))
                        0: it.ticks_per_second = '0;
                        1: it.ticks_per_second = $urandom_range(1000, 1);
                        2: it.ticks_per_second = $urandom_range(65535, 1);
                        3: it.ticks_per_second = $urandom;
                        default: it.ticks_per_second = $urandom >> $urandom_range(31);
                    endcase
                    void'(calibrate_step(plan_state, it));
                    queue_item(it);
                end
                // sender holds off until every tick value is back
                settle();
            end
        end

        if (n_mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: interval_clock_calibrator_unit.f
+incdir+sv
sv/icc_pkg.sv
sv/icc_mul.sv
sv/icc_div.sv
sv/interval_clock_calibrator_unit.sv
sim/tb.sv
